[rtl/assert_macros.svh]
// Assertion macros shared by the unique key stack RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define UKS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("unique_key_stack assertion failed");
// Condition must never be true at a rising edge outside reset.
`define UKS_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("unique_key_stack forbidden condition seen");
`else
`define UKS_ASSERT(lbl, clk, rst, prop)
`define UKS_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

[rtl/uks_pkg.sv]
// Package for the unique key stack: request and status codes, default depth,
// and the structs passed along the cell chain. No dependencies.
package uks_pkg;

   localparam int UKS_DEPTH = 128;
   // Width of an occupancy count that can reach UKS_DEPTH.
   localparam int UKS_CW    = $clog2(UKS_DEPTH + 1);

   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_POP  = 2'd1;
   localparam logic [1:0] REQ_PEEK = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_DUP   = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // One stack record.
   typedef struct packed {
      logic signed [31:0] key;
      logic [63:0]        payload;
   } uks_entry_type;

   // Shift command broadcast to every cell.
   typedef struct packed {
      logic push;
      logic pop;
   } uks_shift_type;

   // Duplicate-search token travelling down the chain.
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic signed [31:0] key;
   } uks_probe_type;

endpackage

[rtl/uks_cell.sv]
// One stack cell: holds a record, shifts with its neighbors, and checks the
// passing search token against its key. Depends on uks_pkg.
module uks_cell import uks_pkg::*; #(
   parameter int CW = UKS_CW
) (
   input  logic          clock,
   input  logic          reset,
   input  uks_shift_type shift,
   input  uks_entry_type up_entry,
   input  uks_entry_type dn_entry,
   output uks_entry_type entry,
   input  uks_probe_type prb_prev,
   input  logic [CW-1:0] left_prev,
   output uks_probe_type prb_next,
   output logic [CW-1:0] left_next
);

   uks_entry_type entry_ff, entry_in;
   uks_probe_type prb_ff, prb_in;
   logic [CW-1:0] left_ff, left_in;
   logic          live;

   // Token still covers occupied entries while its remaining count is nonzero.
   assign live = (left_prev != '0);

   always_comb begin
      entry_in = entry_ff;
      if (shift.push) begin
         entry_in = up_entry;
      end else if (shift.pop) begin
         entry_in = dn_entry;
      end
   end

   always_comb begin
      prb_in.valid = prb_prev.valid;
      prb_in.key   = prb_prev.key;
      prb_in.hit   = prb_prev.hit |
                     (prb_prev.valid & live & (prb_prev.key == entry_ff.key));
      left_in      = live ? (left_prev - CW'(1)) : left_prev;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prb_ff  <= '0;
         left_ff <= '0;
      end else begin
         prb_ff  <= prb_in;
         left_ff <= left_in;
      end
   end

   assign entry     = entry_ff;
   assign prb_next  = prb_ff;
   assign left_next = left_ff;

endmodule

[rtl/unique_key_stack_top.sv]
// unique_key_stack_top: bounded LIFO of (signed 32-bit key, 64-bit payload)
// records with a duplicate-key check on push. Depends on uks_pkg, uks_cell
// and assert_macros.svh.
// Channels: req_* carries one request per transaction (push, pop, peek top);
// rsp_* returns exactly one result per request: status, key, payload and the
// fill level after the request. Both use valid/ready.
// Storage is a row of DEPTH cells, top of stack in cell 0. Push shifts every
// record down one cell, pop shifts every record up one cell.
// A non-full push sends a search token down the chain, one cell per cycle,
// and its result is registered after the token leaves the last cell; pop,
// peek, a push to a full stack and the reserved code skip the search and
// go from acceptance straight to the finish state.
// One request is in flight at a time; the next is accepted once the result
// is registered. The length of the cell chain sets how long a push takes.
// The output register lets a new request enter while a result still waits;
// if the receiver stalls, the finished request holds until rsp_ready.
// Reset (synchronous, active high) empties the stack and drops any pending
// result; record contents are not cleared.
`include "assert_macros.svh"

module unique_key_stack_top import uks_pkg::*; #(
   parameter int DEPTH = UKS_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_call_id,
   input  logic [63:0]        req_payload_handle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_call_id_out,
   output logic [63:0]        rsp_payload_out,
   output logic [7:0]         rsp_fill_level
);

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               dup_ff;
   logic [1:0]         rq_type_ff;
   logic signed [31:0] rq_key_ff;
   logic [63:0]        rq_pay_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic signed [31:0] rsp_key_ff;
   logic [63:0]        rsp_pay_ff;
   logic [7:0]         rsp_fill_ff;

   logic               req_fire;
   logic               fin_fire;
   logic               full;
   logic [1:0]         res_status;
   logic signed [31:0] res_key;
   logic [63:0]        res_pay;
   uks_shift_type      shift;
   uks_entry_type      new_entry;

   // Chain wiring: entry_q[i] is cell i's record; probe index i feeds cell i.
   uks_entry_type      entry_q [DEPTH];
   uks_probe_type      prb_q   [DEPTH+1];
   logic [CW-1:0]      left_q  [DEPTH+1];

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign full      = (count_ff == CW'(DEPTH));
   // Finish only when the output register is free or being emptied.
   assign fin_fire  = (state_ff == S_FIN) & (~rsp_valid_ff | rsp_ready);

   // Inject the search token straight from the accepted transaction; it
   // inspects only the count_ff occupied cells on its way down.
   assign prb_q[0].valid = req_fire & (req_type == REQ_PUSH) & ~full;
   assign prb_q[0].hit   = 1'b0;
   assign prb_q[0].key   = req_call_id;
   assign left_q[0]      = count_ff;

   assign new_entry.key     = rq_key_ff;
   assign new_entry.payload = rq_pay_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      uks_entry_type up_e, dn_e;
      if (g == 0) begin : g_top
         assign up_e = new_entry;
      end else begin : g_mid_up
         assign up_e = entry_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_bottom
         assign dn_e = entry_q[g];
      end else begin : g_mid_dn
         assign dn_e = entry_q[g+1];
      end
      uks_cell #(.CW(CW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .up_entry  (up_e),
         .dn_entry  (dn_e),
         .entry     (entry_q[g]),
         .prb_prev  (prb_q[g]),
         .left_prev (left_q[g]),
         .prb_next  (prb_q[g+1]),
         .left_next (left_q[g+1])
      );
   end

   // Result of the pending request and the stack update it implies.
   always_comb begin
      res_status = ST_OK;
      res_key    = '0;
      res_pay    = '0;
      count_in   = count_ff;
      shift      = '0;
      case (rq_type_ff)
         REQ_PUSH: begin
            if (full) begin
               res_status = ST_FULL;
            end else if (dup_ff) begin
               res_status = ST_DUP;
            end else begin
               shift.push = fin_fire;
               if (fin_fire) begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         REQ_POP, REQ_PEEK: begin
            if (count_ff == '0) begin
               res_status = ST_EMPTY;
            end else begin
               res_key = entry_q[0].key;
               res_pay = entry_q[0].payload;
               if (rq_type_ff == REQ_POP) begin
                  shift.pop = fin_fire;
                  if (fin_fire) begin
                     count_in = count_ff - CW'(1);
                  end
               end
            end
         end
         default: begin
            // Reserved code: no state change, ok status, zero record.
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = prb_q[0].valid ? S_SCAN : S_FIN;
            end
         end
         S_SCAN: begin
            if (prb_q[DEPTH].valid) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (fin_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (fin_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the request fields, the search outcome and the result.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rq_type_ff <= req_type;
         rq_key_ff  <= req_call_id;
         rq_pay_ff  <= req_payload_handle;
      end
      if (state_ff == S_SCAN && prb_q[DEPTH].valid) begin
         dup_ff <= prb_q[DEPTH].hit;
      end
      if (fin_fire) begin
         rsp_status_ff <= res_status;
         rsp_key_ff    <= res_key;
         rsp_pay_ff    <= res_pay;
         rsp_fill_ff   <= 8'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_call_id_out = rsp_key_ff;
   assign rsp_payload_out = rsp_pay_ff;
   assign rsp_fill_level  = rsp_fill_ff;

   `UKS_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `UKS_ASSERT(a_probe_exit_in_scan, clock, reset, prb_q[DEPTH].valid |-> state_ff == S_SCAN)
   `UKS_ASSERT(a_push_scans, clock, reset, prb_q[0].valid |=> state_ff == S_SCAN)
   `UKS_ASSERT(a_push_grows, clock, reset, shift.push |=> count_ff == $past(count_ff) + CW'(1))
   `UKS_ASSERT_NEVER(a_no_shift_in_scan, clock, reset, state_ff == S_SCAN && (shift.push || shift.pop))

endmodule
